/* rtl/slwm_pkg.sv */
// Package with the item types, command codes and constants of the LIKE matcher.
package slwm_pkg;

  localparam int unsigned PatternMax = 64;
  localparam int unsigned CmdDepth   = 2;
  localparam int unsigned ResDepth   = 2;

  localparam logic [7:0] AnyRun = 8'h25;
  localparam logic [7:0] AnyOne = 8'h5F;

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindAppend = 2'd1,
    KindText   = 2'd2,
    KindEnd    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  typedef struct packed {
    kind_e      op;
    logic [7:0] ch;
    logic       any_run;
    logic       any_one;
  } cmd_t;

endpackage

/* rtl/slwm_fifo.sv */
// Small generic first-in first-out queue built from registers.
module slwm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/slwm_front.sv */
// Front end: accepts input items, decodes them into commands and queues them.
module slwm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slwm_pkg::in_item_t item_i,
  output logic               full_o,
  input  logic               cmd_pop_i,
  output slwm_pkg::cmd_t     cmd_o,
  output logic               cmd_empty_o
);

  slwm_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.op      = slwm_pkg::kind_e'(item_i.kind);
    cmd_in.ch      = item_i.ch;
    cmd_in.any_run = (item_i.ch == slwm_pkg::AnyRun);
    cmd_in.any_one = (item_i.ch == slwm_pkg::AnyOne);
  end

  slwm_fifo #(
    .Width($bits(slwm_pkg::cmd_t)),
    .Depth(slwm_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(cmd_empty_o)
  );

endmodule

/* rtl/slwm_back.sv */
// Back end: pattern store, active-position set and end-of-text evaluation.
module slwm_back #(
  parameter int unsigned PatternMax = slwm_pkg::PatternMax
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slwm_pkg::cmd_t      cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output slwm_pkg::out_item_t res_o
);

  localparam int unsigned LenW = $clog2(PatternMax + 1);

  logic [PatternMax-1:0] valid_q, valid_d;
  logic [PatternMax-1:0] run_q, run_d;
  logic [PatternMax-1:0] one_q, one_d;
  logic [7:0]            byte_q [PatternMax];
  logic [7:0]            byte_d [PatternMax];
  logic [LenW-1:0]       len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [PatternMax:0]   act_q, act_d;

  logic [PatternMax:0]   run_vec, seed, sum, closed, nxt;
  logic                  exec, store_full, live;

  assign exec       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = exec;
  assign res_push_o = exec && (cmd_i.op == slwm_pkg::KindEnd);
  assign store_full = (len_q == LenW'(PatternMax));

  // Closure over runs of the any-run wildcard is a carry chain: each active
  // wildcard position generates, each further wildcard propagates.
  assign run_vec = {1'b0, run_q & valid_q};
  assign seed    = run_vec & act_q;
  assign sum     = run_vec + seed;
  assign closed  = act_q | (sum ^ run_vec ^ seed);

  always_comb begin
    nxt  = '0;
    live = 1'b0;
    for (int i = 0; i < PatternMax; i++) begin
      live = closed[i] && valid_q[i];
      if (live && run_q[i]) begin
        nxt[i] = 1'b1;
      end
      if (live && !run_q[i] && (one_q[i] || (byte_q[i] == cmd_i.ch))) begin
        nxt[i+1] = 1'b1;
      end
    end
  end

  assign res_o.matched          = closed[len_q] && !ovf_q;
  assign res_o.pattern_overflow = ovf_q;

  always_comb begin
    valid_d = valid_q;
    run_d   = run_q;
    one_d   = one_q;
    byte_d  = byte_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    act_d   = act_q;
    if (exec) begin
      case (cmd_i.op)
        slwm_pkg::KindClear: begin
          valid_d = '0;
          len_d   = '0;
          ovf_d   = 1'b0;
          act_d   = (PatternMax + 1)'(1);
        end
        slwm_pkg::KindAppend: begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            for (int i = 0; i < PatternMax; i++) begin
              if (len_q == LenW'(i)) begin
                valid_d[i] = 1'b1;
                run_d[i]   = cmd_i.any_run;
                one_d[i]   = cmd_i.any_one;
                byte_d[i]  = cmd_i.ch;
              end
            end
            len_d = len_q + LenW'(1);
          end
          act_d = (PatternMax + 1)'(1);
        end
        slwm_pkg::KindText: begin
          act_d = nxt;
        end
        slwm_pkg::KindEnd: begin
          act_d = (PatternMax + 1)'(1);
        end
        default: begin
          act_d = act_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      act_q   <= (PatternMax + 1)'(1);
    end else begin
      valid_q <= valid_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    one_q  <= one_d;
    byte_q <= byte_d;
  end

`ifndef SYNTHESIS
  a_act_within_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q[PatternMax:1] & ~valid_q) == '0)
    else $error("Active position beyond the stored pattern.");

  a_valid_matches_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(len_q))
    else $error("Valid positions disagree with the pattern length.");

  a_ovf_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> store_full)
    else $error("Overflow flagged while the store still has room.");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cmd_i.op == slwm_pkg::KindClear) |=> (len_q == '0 && !ovf_q))
    else $error("Clear did not empty the pattern store.");
`endif

endmodule

/* rtl/sql_like_wildcard_matcher.sv */
// Top level of the anchored SQL LIKE wildcard matcher.
//
//   Channel  Handshake     Payload    Direction
//   input    push / full   item_i     in: kind and byte
//   result   pop / empty   result_o   out: matched and overflow flag
//
// Items stream at one per cycle while the result queue has room.
// A result is visible once its end-of-text item has been accepted: the
// command queue hands the item to the back end, and the back end queues
// the result as the item leaves the command queue.
// Reset leaves an empty pattern with only position zero active.
// The back end holds every item while the two-entry result queue is full;
// the two-entry front queue keeps the input open for a while meanwhile.
module sql_like_wildcard_matcher #(
  parameter int unsigned PatternMax = slwm_pkg::PatternMax
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  slwm_pkg::in_item_t  item_i,
  output logic                full,
  input  logic                pop,
  output slwm_pkg::out_item_t result_o,
  output logic                empty
);

  slwm_pkg::cmd_t      cmd;
  slwm_pkg::out_item_t res;
  logic                cmd_empty, cmd_pop, res_full, res_push;

  slwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  slwm_back #(
    .PatternMax(PatternMax)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  slwm_fifo #(
    .Width($bits(slwm_pkg::out_item_t)),
    .Depth(slwm_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule
